// File: hdl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg: shared constants for the heap sort engine
// Data width and default store depth used by the engine and its compare unit.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

endpackage

// File: hdl/hse_cmp.sv
// ----------------------------------------------------------------------------
// hse_cmp: shared signed compare unit
// Flags when operand a is strictly greater than operand b, two's complement.
// ----------------------------------------------------------------------------
module hse_cmp
  import hse_pkg::*;
(
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output logic                     gt
);

  assign gt = (op_a > op_b);

endmodule

// File: hdl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine: collect a set of signed values and emit it sorted
// Values are stored one per item; the item with in_last closes the set, which
// is then sorted in place by heap sort and streamed out smallest first.
// ----------------------------------------------------------------------------
// channel   ports                                         handshake
// input     in_value, in_last                             start & !busy
// result    out_sorted_value, out_final_res, out_overflow out_valid, no stall
//
// Values without in_last are accepted back to back while the engine is idle.
// On the closing item the engine sorts with one read port, one write port and
// one shared comparator: each sift loads its root, then per level reads and
// compares the left child and any right child and moves the larger up if it
// beats the root, and finally writes the root back. Results then stream out,
// each in the cycle after its read. Results cannot be stalled. Reset clears
// the fill count and overflow flag; no clearing pass runs over the store.
// ----------------------------------------------------------------------------
module heap_sort_engine
  import hse_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_overflow
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int IW = AW + 1;
  localparam int XW = IW + 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_BLD  = 13'b0000000000010,
    S_RDN  = 13'b0000000000100,
    S_LDN  = 13'b0000000001000,
    S_CHL  = 13'b0000000010000,
    S_CHR  = 13'b0000000100000,
    S_CMPR = 13'b0000001000000,
    S_MOVE = 13'b0000010000000,
    S_FIN  = 13'b0000100000000,
    S_EXT  = 13'b0001000000000,
    S_EX1  = 13'b0010000000000,
    S_EX2  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] mem_r [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] mem_q_r;

  logic [IW-1:0]            cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [IW-1:0]            n_r, n_nxt;
  logic [IW-1:0]            size_r, size_nxt;
  logic [AW-1:0]            node_r, node_nxt;
  logic signed [DATA_W-1:0] sv_r, sv_nxt;
  logic signed [DATA_W-1:0] top_v_r, top_v_nxt;
  logic [AW-1:0]            top_i_r, top_i_nxt;
  logic                     moved_r, moved_nxt;
  logic                     bld_r, bld_nxt;
  logic [IW-1:0]            bk_r, bk_nxt;
  logic [IW-1:0]            ek_r, ek_nxt;
  logic [AW-1:0]            oi_r, oi_nxt;
  logic                     pend_r, pend_nxt;
  logic                     pend_last_r, pend_last_nxt;
  logic                     pend_ovf_r, pend_ovf_nxt;

  logic                     rd_en;
  logic [AW-1:0]            rd_a;
  logic                     wr_en;
  logic [AW-1:0]            wr_a;
  logic signed [DATA_W-1:0] wr_d;

  logic                     has_room;
  logic [IW-1:0]            cnt_sum;
  logic [XW-1:0]            lc_x;
  logic [XW-1:0]            rc_x;
  logic [XW-1:0]            size_x;
  logic                     oi_last;
  logic signed [DATA_W-1:0] cmp_b;
  logic                     cmp_gt;

  hse_cmp u_cmp (
    .op_a (mem_q_r),
    .op_b (cmp_b),
    .gt   (cmp_gt)
  );

  assign cmp_b    = (state_r == S_CHR) ? sv_r : top_v_r;
  assign has_room = (cnt_r < IW'(MAX_ELEMENTS));
  assign cnt_sum  = has_room ? (cnt_r + IW'(1)) : cnt_r;
  assign lc_x     = {1'b0, node_r, 1'b1};
  assign rc_x     = lc_x + XW'(1);
  assign size_x   = {1'b0, size_r};
  assign oi_last  = ({1'b0, oi_r} == (n_r - IW'(1)));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    size_nxt      = size_r;
    node_nxt      = node_r;
    sv_nxt        = sv_r;
    top_v_nxt     = top_v_r;
    top_i_nxt     = top_i_r;
    moved_nxt     = moved_r;
    bld_nxt       = bld_r;
    bk_nxt        = bk_r;
    ek_nxt        = ek_r;
    oi_nxt        = oi_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    pend_ovf_nxt  = pend_ovf_r;
    rd_en         = 1'b0;
    rd_a          = '0;
    wr_en         = 1'b0;
    wr_a          = '0;
    wr_d          = sv_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          wr_en   = has_room;
          wr_a    = cnt_r[AW-1:0];
          wr_d    = in_value;
          cnt_nxt = cnt_sum;
          ovf_nxt = ovf_r | ~has_room;
          if (in_last) begin
            n_nxt     = cnt_sum;
            bk_nxt    = cnt_sum >> 1;
            ek_nxt    = cnt_sum - IW'(1);
            oi_nxt    = '0;
            bld_nxt   = 1'b1;
            state_nxt = S_BLD;
          end
        end
      end
      S_BLD: begin
        if (bk_r == '0) begin
          bld_nxt   = 1'b0;
          state_nxt = S_EXT;
        end else begin
          node_nxt  = AW'(bk_r - IW'(1));
          bk_nxt    = bk_r - IW'(1);
          size_nxt  = n_r;
          state_nxt = S_RDN;
        end
      end
      S_RDN: begin
        rd_en     = 1'b1;
        rd_a      = node_r;
        state_nxt = S_LDN;
      end
      S_LDN: begin
        sv_nxt    = mem_q_r;
        state_nxt = S_CHL;
      end
      S_CHL: begin
        if (lc_x < size_x) begin
          rd_en     = 1'b1;
          rd_a      = lc_x[AW-1:0];
          state_nxt = S_CHR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CHR: begin
        if (cmp_gt) begin
          top_v_nxt = mem_q_r;
          top_i_nxt = lc_x[AW-1:0];
          moved_nxt = 1'b1;
        end else begin
          top_v_nxt = sv_r;
          moved_nxt = 1'b0;
        end
        if (rc_x < size_x) begin
          rd_en     = 1'b1;
          rd_a      = rc_x[AW-1:0];
          state_nxt = S_CMPR;
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_CMPR: begin
        if (cmp_gt) begin
          top_v_nxt = mem_q_r;
          top_i_nxt = rc_x[AW-1:0];
          moved_nxt = 1'b1;
        end
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        if (moved_r) begin
          wr_en     = 1'b1;
          wr_a      = node_r;
          wr_d      = top_v_r;
          node_nxt  = top_i_r;
          state_nxt = S_CHL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        wr_en     = 1'b1;
        wr_a      = node_r;
        wr_d      = sv_r;
        state_nxt = bld_r ? S_BLD : S_EXT;
      end
      S_EXT: begin
        if (ek_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_a      = ek_r[AW-1:0];
          state_nxt = S_EX1;
        end
      end
      S_EX1: begin
        sv_nxt    = mem_q_r;
        rd_en     = 1'b1;
        rd_a      = '0;
        state_nxt = S_EX2;
      end
      S_EX2: begin
        wr_en     = 1'b1;
        wr_a      = ek_r[AW-1:0];
        wr_d      = mem_q_r;
        node_nxt  = '0;
        size_nxt  = ek_r;
        ek_nxt    = ek_r - IW'(1);
        state_nxt = S_CHL;
      end
      S_OUT: begin
        rd_en         = 1'b1;
        rd_a          = oi_r;
        pend_nxt      = 1'b1;
        pend_last_nxt = oi_last;
        pend_ovf_nxt  = ovf_r;
        oi_nxt        = oi_r + AW'(1);
        if (oi_last) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_a] <= wr_d;
    end
    if (rd_en) begin
      mem_q_r <= mem_r[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    size_r      <= size_nxt;
    node_r      <= node_nxt;
    sv_r        <= sv_nxt;
    top_v_r     <= top_v_nxt;
    top_i_r     <= top_i_nxt;
    moved_r     <= moved_nxt;
    bld_r       <= bld_nxt;
    bk_r        <= bk_nxt;
    ek_r        <= ek_nxt;
    oi_r        <= oi_nxt;
    pend_last_r <= pend_last_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = pend_r;
  assign out_sorted_value = mem_q_r;
  assign out_final_res    = pend_last_r;
  assign out_overflow     = pend_ovf_r;

endmodule

// File: tb/heap_sort_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_sort_engine_tb: self-checking bench for the heap sort engine
// Sends sets of signed values (directed table, then random sets including a
// full store and an overfull one), predicts each sorted stream and checks
// every result against it.
// ----------------------------------------------------------------------------
module heap_sort_engine_tb
  import hse_pkg::*;
();

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     is_final;
    logic                     ovf;
  } sorted_rec_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     typed;
    logic signed [DATA_W-1:0] typed_value;
  } stim_row_t;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     start    = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last  = 1'b0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_final_res;
  logic                     out_overflow;

  sorted_rec_t              sorted_expect[$];
  logic signed [DATA_W-1:0] held_set[$];
  logic                     set_overflow = 1'b0;
  stim_row_t                stim_rows[$];
  int                       mismatch_count = 0;

  heap_sort_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS_DEF)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_sorted_value(out_sorted_value),
    .out_final_res   (out_final_res),
    .out_overflow    (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_row(logic signed [DATA_W-1:0] v, logic l, logic typed,
                                   logic signed [DATA_W-1:0] typed_value);
    stim_row_t row;
    row.value       = v;
    row.last        = l;
    row.typed       = typed;
    row.typed_value = typed_value;
    stim_rows.push_back(row);
  endfunction

  task automatic drive_item(input logic signed [DATA_W-1:0] v, input logic l);
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // keep the held set in ascending order; close it on last
  task automatic absorb_item(input logic signed [DATA_W-1:0] v, input logic l,
                             input logic typed, input logic signed [DATA_W-1:0] typed_value);
    int          pos;
    sorted_rec_t rec;
    if (held_set.size() < MAX_ELEMENTS_DEF) begin
      pos = 0;
      while (pos < held_set.size() && held_set[pos] <= v) pos++;
      held_set.insert(pos, v);
    end else begin
      set_overflow = 1'b1;
    end
    if (l) begin
      if (typed) begin
        rec.value    = typed_value;
        rec.is_final = 1'b1;
        rec.ovf      = 1'b0;
        sorted_expect.push_back(rec);
      end else begin
        for (int k = 0; k < held_set.size(); k++) begin
          rec.value    = held_set[k];
          rec.is_final = (k == held_set.size() - 1);
          rec.ovf      = set_overflow;
          sorted_expect.push_back(rec);
        end
      end
      held_set.delete();
      set_overflow = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    sorted_rec_t exp_rec;
    if (rst_n && out_valid) begin
      if (sorted_expect.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none, actual value %0d final %0b ovf %0b",
                 $time, out_sorted_value, out_final_res, out_overflow);
      end else begin
        exp_rec = sorted_expect.pop_front();
        if (out_sorted_value !== exp_rec.value) begin
          mismatch_count++;
          $display("%0t: sorted_value expected %0d actual %0d",
                   $time, exp_rec.value, out_sorted_value);
        end
        if (out_final_res !== exp_rec.is_final) begin
          mismatch_count++;
          $display("%0t: final_res expected %0b actual %0b",
                   $time, exp_rec.is_final, out_final_res);
        end
        if (out_overflow !== exp_rec.ovf) begin
          mismatch_count++;
          $display("%0t: overflow expected %0b actual %0b",
                   $time, exp_rec.ovf, out_overflow);
        end
      end
    end
  end

  initial begin : main_seq
    logic signed [DATA_W-1:0] v;
    int                       set_idx;
    int                       set_size;
    int                       val_mode;
    int                       random_items;
    int                       idle_pct;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(VAL_MAX, 1'b1, 1'b1, VAL_MAX);
    add_row(VAL_MIN, 1'b1, 1'b1, VAL_MIN);
    add_row('0, 1'b1, 1'b1, '0);
    add_row(-1, 1'b1, 1'b1, -1);
    add_row(5, 1'b0, 1'b0, '0);
    add_row(-3, 1'b0, 1'b0, '0);
    add_row(VAL_MAX, 1'b0, 1'b0, '0);
    add_row(VAL_MIN, 1'b0, 1'b0, '0);
    add_row(0, 1'b1, 1'b0, '0);
    add_row(7, 1'b0, 1'b0, '0);
    add_row(7, 1'b0, 1'b0, '0);
    add_row(7, 1'b0, 1'b0, '0);
    add_row(7, 1'b1, 1'b0, '0);
    add_row(40, 1'b0, 1'b0, '0);
    add_row(30, 1'b0, 1'b0, '0);
    add_row(20, 1'b0, 1'b0, '0);
    add_row(10, 1'b1, 1'b0, '0);
    add_row(100, 1'b0, 1'b0, '0);
    add_row(-100, 1'b1, 1'b0, '0);
    add_row(32'sh5555_5555, 1'b0, 1'b0, '0);
    add_row(32'shAAAA_AAAA, 1'b1, 1'b0, '0);
    add_row(1, 1'b1, 1'b1, 1);

    foreach (stim_rows[i]) begin
      drive_item(stim_rows[i].value, stim_rows[i].last);
      absorb_item(stim_rows[i].value, stim_rows[i].last, stim_rows[i].typed,
                  stim_rows[i].typed_value);
    end

    // hold off until the engine has drained every set
    start <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);

    set_idx      = 0;
    random_items = 0;
    while (random_items < 178) begin
      if (set_idx == 2)
        set_size = MAX_ELEMENTS_DEF;
      else if (set_idx == 5)
        set_size = MAX_ELEMENTS_DEF + 3;
      else
        set_size = $urandom_range(1, 10);
      val_mode = $urandom_range(0, 3);
      for (int k = 0; k < set_size; k++) begin
        case (val_mode)
          0: v = int'($urandom_range(0, 8)) - 4;
          1: begin
            case ($urandom_range(0, 3))
              0:       v = VAL_MIN;
              1:       v = VAL_MAX;
              2:       v = '0;
              default: v = -1;
            endcase
          end
          default: v = $urandom;
        endcase
        idle_pct = (random_items < 60) ? 11 : (random_items < 120) ? 67 : 0;
        drive_item(v, k == set_size - 1);
        absorb_item(v, k == set_size - 1, 1'b0, '0);
        random_items++;
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 3)) @(posedge clk);
        end
      end
      set_idx++;
    end

    start <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
